/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/erxaf_pkg.sv */
// Shared widths, codes, flag struct and match priority for the address filter.
`timescale 1ns / 1ps

package erxaf_pkg;

   localparam int MacWidth       = 48;
   localparam int CrcWidth       = 32;
   localparam int KindWidth      = 3;
   localparam int ModeWidth      = 3;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 64;
   localparam int HashRegWidth   = 64;
   localparam int HashBits       = 256;
   localparam int HashIndexWidth = 8;

   localparam int ModePromisc  = 0;
   localparam int ModeAllMulti = 1;
   localparam int ModeHash     = 2;

   localparam int GroupBit = 40;

   localparam logic [MacWidth-1:0] BroadcastMac = '1;

   localparam logic [KindWidth-1:0] KIND_NONE      = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PROMISC   = 3'd1;
   localparam logic [KindWidth-1:0] KIND_BCAST     = 3'd2;
   localparam logic [KindWidth-1:0] KIND_ALLMCAST  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_HASHMCAST = 3'd4;
   localparam logic [KindWidth-1:0] KIND_PRIMARY   = 3'd5;
   localparam logic [KindWidth-1:0] KIND_ALTERNATE = 3'd6;

   localparam logic [CsrIndexWidth-1:0] CSR_FILTER_MODE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIMARY     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ALTERNATE   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HASH_0_3    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_HASH_4_7    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_HASH_8_11   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_HASH_12_15  = 3'd6;

   typedef struct packed {
      logic promisc;
      logic all_multi;
      logic bcast;
      logic group;
      logic hash_hit;
      logic primary_hit;
      logic alternate_hit;
   } flags_type;

   function automatic logic [KindWidth-1:0] match_kind_of(flags_type f);
      logic [KindWidth-1:0] kind;
      kind = KIND_NONE;
      priority if (f.promisc) begin
         kind = KIND_PROMISC;
      end else if (f.bcast) begin
         kind = KIND_BCAST;
      end else if (f.group) begin
         if (f.all_multi) begin
            kind = KIND_ALLMCAST;
         end else if (f.hash_hit) begin
            kind = KIND_HASHMCAST;
         end else begin
            kind = KIND_NONE;
         end
      end else if (f.primary_hit) begin
         kind = KIND_PRIMARY;
      end else if (f.alternate_hit) begin
         kind = KIND_ALTERNATE;
      end else begin
         kind = KIND_NONE;
      end
      return kind;
   endfunction

endpackage

/* hw/rtl/erxaf_classify.sv */
// Address compares and multicast hash lookup for one destination address.
`timescale 1ns / 1ps

module erxaf_classify
   import erxaf_pkg::*;
(
   input  logic [MacWidth-1:0]  mac,
   input  logic [CrcWidth-1:0]  crc,
   input  logic [ModeWidth-1:0] mode,
   input  logic [MacWidth-1:0]  primary_address,
   input  logic [MacWidth-1:0]  alternate_address,
   input  logic [HashBits-1:0]  hash_table,
   output flags_type            flags
);

   logic [HashIndexWidth-1:0] hash_index;

   // word from crc[31:28], bit 15 - crc[27:24] is the inverted nibble
   assign hash_index = {crc[31:28], ~crc[27:24]};

   always_comb begin
      flags.promisc       = mode[ModePromisc];
      flags.all_multi     = mode[ModeAllMulti];
      flags.bcast         = (mac == BroadcastMac);
      flags.group         = mac[GroupBit];
      flags.hash_hit      = mode[ModeHash] & hash_table[hash_index];
      flags.primary_hit   = (mac == primary_address);
      flags.alternate_hit = (mac == alternate_address);
   end

endmodule

/* hw/rtl/ethernet_rx_address_filter_unit.sv */
// Top level of the receive destination address filter: registers and pipeline.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   req     | req_valid/req_stall, dest_mac, crc | in
//   rsp     | rsp_valid/rsp_stall, match_kind    | out
//   csr     | csr_wr_en, csr_index, csr_wdata    | in
//
// One item per cycle enters while req_stall is low; each result leaves from the last stage.
// Stages: input capture, compare and hash lookup, priority encode.
// Synchronous reset clears the valid bits and all filter registers.
// A stalled result holds; each stage advances when the one after it frees up.
`timescale 1ns / 1ps

module ethernet_rx_address_filter_unit
   import erxaf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MacWidth-1:0]      req_dest_mac,
   input  logic [CrcWidth-1:0]      req_frame_crc,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [KindWidth-1:0]     rsp_match_kind,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic [ModeWidth-1:0]    mode_ff, mode_in;
   logic [MacWidth-1:0]     primary_ff, primary_in;
   logic [MacWidth-1:0]     alternate_ff, alternate_in;
   logic [HashRegWidth-1:0] hash0_ff, hash0_in;
   logic [HashRegWidth-1:0] hash1_ff, hash1_in;
   logic [HashRegWidth-1:0] hash2_ff, hash2_in;
   logic [HashRegWidth-1:0] hash3_ff, hash3_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [MacWidth-1:0]     s1_mac_ff;
   logic [CrcWidth-1:0]     s1_crc_ff;
   logic                    s2_valid_ff, s2_valid_in;
   flags_type               s2_flags_ff, s2_flags_in;
   logic                    s3_valid_ff, s3_valid_in;
   logic [KindWidth-1:0]    s3_kind_ff, s3_kind_in;

   logic                    s1_ready;
   logic                    s2_ready;
   logic                    s3_ready;

   always_comb begin
      mode_in      = mode_ff;
      primary_in   = primary_ff;
      alternate_in = alternate_ff;
      hash0_in     = hash0_ff;
      hash1_in     = hash1_ff;
      hash2_in     = hash2_ff;
      hash3_in     = hash3_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FILTER_MODE: mode_in      = csr_wdata[ModeWidth-1:0];
            CSR_PRIMARY:     primary_in   = csr_wdata[MacWidth-1:0];
            CSR_ALTERNATE:   alternate_in = csr_wdata[MacWidth-1:0];
            CSR_HASH_0_3:    hash0_in     = csr_wdata;
            CSR_HASH_4_7:    hash1_in     = csr_wdata;
            CSR_HASH_8_11:   hash2_in     = csr_wdata;
            CSR_HASH_12_15:  hash3_in     = csr_wdata;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         primary_ff   <= '0;
         alternate_ff <= '0;
         hash0_ff     <= '0;
         hash1_ff     <= '0;
         hash2_ff     <= '0;
         hash3_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         primary_ff   <= primary_in;
         alternate_ff <= alternate_in;
         hash0_ff     <= hash0_in;
         hash1_ff     <= hash1_in;
         hash2_ff     <= hash2_in;
         hash3_ff     <= hash3_in;
      end
   end

   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   erxaf_classify u_classify (
      .mac               (s1_mac_ff),
      .crc               (s1_crc_ff),
      .mode              (mode_ff),
      .primary_address   (primary_ff),
      .alternate_address (alternate_ff),
      .hash_table        ({hash3_ff, hash2_ff, hash1_ff, hash0_ff}),
      .flags             (s2_flags_in)
   );

   assign s3_kind_in = match_kind_of(s2_flags_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_mac_ff <= req_dest_mac;
         s1_crc_ff <= req_frame_crc;
      end
      if (s2_ready) begin
         s2_flags_ff <= s2_flags_in;
      end
      if (s3_ready) begin
         s3_kind_ff <= s3_kind_in;
      end
   end

   assign rsp_valid      = s3_valid_ff;
   assign rsp_match_kind = s3_kind_ff;

endmodule

/* hw/rtl/erxaf_checker.sv */
// Port-level checker for the address filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module erxaf_checker
   import erxaf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [KindWidth-1:0] rsp_match_kind
);

   logic req_seen;

   assign req_seen = req_valid | ~req_valid;

   `ASSERT_DIS(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")
   `ASSERT_DIS(a_rsp_hold_kind, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_match_kind), "rsp_match_kind changed while stalled")
   `ASSERT_DIS(a_kind_range, clock, reset, rsp_valid |-> (rsp_match_kind <= KIND_ALTERNATE), "rsp_match_kind out of range")
   `ASSERT_DIS(a_no_back_stall, clock, reset, req_seen && !rsp_stall |-> !req_stall, "req_stall raised while the output is free")
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "rsp_valid high right after reset")

endmodule

bind ethernet_rx_address_filter_unit erxaf_checker u_erxaf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_match_kind (rsp_match_kind)
);
